// ===== rtl/core/csdm_pkg.sv =====
`timescale 1ns / 1ps
package csdm_pkg;

  localparam int MAX_LEN_DEF     = 64;
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int CHAR_W          = 8;
  localparam int CFG_W           = 7;
  localparam int INDEX_W         = 10;
  localparam int HASH_W          = 32;
  localparam logic [HASH_W-1:0] HASH_SEED = 32'd13131;
  localparam logic [CFG_W-1:0]  STR_LEN_RESET = 7'd1;

  typedef enum logic [3:0] {
    ST_RECV,
    ST_ROT_RD,
    ST_ROT_EV,
    ST_HSH_INIT,
    ST_HSH_RD,
    ST_HSH_EV,
    ST_SCN_RD,
    ST_SCN_EV,
    ST_BYT_RD,
    ST_BYT_EV,
    ST_STORE
  } state_t;

  typedef struct packed {
    logic take;
    logic rot_eval;
    logic hash_init;
    logic hash_eval;
    logic scan_eval;
    logic byte_eval;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic str_done;
    logic n_one;
    logic rot_done;
    logic i_last;
    logic j_last;
    logic count_zero;
    logic hash_eq;
    logic byte_eq;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/core/csdm_char_if.sv =====
`timescale 1ns / 1ps
interface csdm_char_if;
  logic                     valid;
  logic                     ready;
  logic [csdm_pkg::CHAR_W-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

// ===== rtl/core/csdm_result_if.sv =====
`timescale 1ns / 1ps
interface csdm_result_if;
  logic                         valid;
  logic                         ready;
  logic [csdm_pkg::INDEX_W-1:0] match_index;
  logic                         was_duplicate;
  logic                         table_full;

  modport source (output valid, output match_index, output was_duplicate,
                  output table_full, input ready);
  modport sink   (input valid, input match_index, input was_duplicate,
                  input table_full, output ready);
endinterface

// ===== rtl/core/cyclic_string_dedup_matcher_top.sv =====
`timescale 1ns / 1ps
// Takes one byte per cycle while in the receive state, until n bytes are in.
// After the last byte: rotation search, skipped when n is 1 (a line buffer
// port pair read in one state and compared in the next), hash pass over the
// n canonical bytes, scan of stored entries up to the first match with a byte
// compare per hash hit, then commit; the result is registered and held until taken.
// Reset (rst, synchronous): dictionary empty, string_length 1, no clearing pass.
module cyclic_string_dedup_matcher_top #(
  parameter int MAX_LEN     = csdm_pkg::MAX_LEN_DEF,
  parameter int MAX_ENTRIES = csdm_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [csdm_pkg::CFG_W-1:0] cfg_data,
  csdm_char_if.sink                  char_in,
  csdm_result_if.source              result_out
);
  import csdm_pkg::*;

  cmd_t    cmd;
  status_t sts;

  csdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  csdm_datapath #(
    .MAX_LEN     (MAX_LEN),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (char_in.valid),
    .char_byte     (char_in.char_byte),
    .out_ready     (result_out.ready),
    .out_valid     (result_out.valid),
    .match_index   (result_out.match_index),
    .was_duplicate (result_out.was_duplicate),
    .table_full    (result_out.table_full),
    .cmd           (cmd),
    .sts           (sts)
  );

  assign char_in.ready = cmd.take;

  // drop input ready once a string completes
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && char_in.valid && sts.str_done) |=> !cmd.take)
    else $error("input still taken after last byte of string");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(cmd.commit))
    else $error("result valid without commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(result_out.valid && !result_out.ready))
    else $error("commit over a pending result");
endmodule

// ===== rtl/core/csdm_ctrl.sv =====
`timescale 1ns / 1ps
module csdm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  csdm_pkg::status_t sts,
  output csdm_pkg::cmd_t    cmd
);
  import csdm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: begin
        if (in_valid && sts.str_done) begin
          state_next = sts.n_one ? ST_HSH_INIT : ST_ROT_RD;
        end
      end
      ST_ROT_RD:   state_next = ST_ROT_EV;
      ST_ROT_EV:   state_next = sts.rot_done ? ST_HSH_INIT : ST_ROT_RD;
      ST_HSH_INIT: state_next = ST_HSH_RD;
      ST_HSH_RD:   state_next = ST_HSH_EV;
      ST_HSH_EV: begin
        if (sts.i_last) begin
          state_next = sts.count_zero ? ST_STORE : ST_SCN_RD;
        end else begin
          state_next = ST_HSH_RD;
        end
      end
      ST_SCN_RD: state_next = ST_SCN_EV;
      ST_SCN_EV: begin
        if (sts.hash_eq) begin
          state_next = ST_BYT_RD;
        end else begin
          state_next = sts.j_last ? ST_STORE : ST_SCN_RD;
        end
      end
      ST_BYT_RD: state_next = ST_BYT_EV;
      ST_BYT_EV: begin
        if (!sts.byte_eq) begin
          state_next = sts.j_last ? ST_STORE : ST_SCN_RD;
        end else begin
          state_next = sts.i_last ? ST_STORE : ST_BYT_RD;
        end
      end
      ST_STORE: begin
        if (!sts.out_busy) begin
          state_next = ST_RECV;
        end
      end
      default: state_next = ST_RECV;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_RECV:     cmd.take      = 1'b1;
      ST_ROT_EV:   cmd.rot_eval  = 1'b1;
      ST_HSH_INIT: cmd.hash_init = 1'b1;
      ST_HSH_EV:   cmd.hash_eval = 1'b1;
      ST_SCN_EV:   cmd.scan_eval = 1'b1;
      ST_BYT_EV:   cmd.byte_eval = 1'b1;
      ST_STORE:    cmd.commit    = !sts.out_busy;
      default:     cmd = '0;
    endcase
  end
endmodule

// ===== rtl/core/csdm_datapath.sv =====
`timescale 1ns / 1ps
module csdm_datapath #(
  parameter int MAX_LEN     = csdm_pkg::MAX_LEN_DEF,
  parameter int MAX_ENTRIES = csdm_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [csdm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic [csdm_pkg::CHAR_W-1:0]  char_byte,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [csdm_pkg::INDEX_W-1:0] match_index,
  output logic                         was_duplicate,
  output logic                         table_full,
  input  csdm_pkg::cmd_t               cmd,
  output csdm_pkg::status_t            sts
);
  import csdm_pkg::*;

  localparam int LW  = $clog2(MAX_LEN);
  localparam int NW  = $clog2(MAX_LEN + 1);
  localparam int EW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int LXW = (NW > CFG_W) ? NW : CFG_W;
  localparam int AW  = EW + LW;

  logic [CHAR_W-1:0] line_mem  [MAX_LEN];
  logic [CHAR_W-1:0] canon_mem [2**AW];
  logic [HASH_W-1:0] hash_mem  [MAX_ENTRIES];

  logic [CFG_W-1:0]  string_length;
  logic [NW-1:0]     pos;
  logic [CW-1:0]     count;
  logic [LW-1:0]     pa, pb, k, best, i;
  logic [EW-1:0]     j, match;
  logic              found;
  logic [HASH_W-1:0] h;
  logic [CHAR_W-1:0] rd_a, rd_b, rd_canon;
  logic [HASH_W-1:0] rd_hash;
  logic [INDEX_W-1:0] out_match;
  logic              out_dup, out_full;

  logic [LXW-1:0]    len_ext;
  logic [NW-1:0]     n;
  logic [NW-1:0]     pos_inc;
  logic              full;
  logic              k_last, rot_diff;
  logic [LW-1:0]     pa_adv, k_inc, best_new;
  logic [HASH_W-1:0] h_mul;

  always_comb begin
    len_ext = LXW'(string_length);
    if (len_ext == '0) begin
      n = NW'(1);
    end else if (len_ext > LXW'(MAX_LEN)) begin
      n = NW'(MAX_LEN);
    end else begin
      n = NW'(len_ext);
    end
  end

  assign pos_inc  = pos + NW'(1);
  assign full     = (count == CW'(MAX_ENTRIES));
  assign pa_adv   = (NW'(pa) == n - NW'(1)) ? '0 : pa + LW'(1);
  assign k_inc    = k + LW'(1);
  assign k_last   = (NW'(k) == n - NW'(1));
  assign rot_diff = (rd_a != rd_b);
  assign best_new = (rot_diff && rd_a < rd_b) ? k : best;
  assign h_mul    = h * HASH_SEED;

  always_comb begin
    sts.str_done   = (pos_inc >= n);
    sts.n_one      = (n == NW'(1));
    sts.i_last     = (NW'(i) == n - NW'(1));
    sts.rot_done   = (rot_diff || sts.i_last) && k_last;
    sts.j_last     = ((CW'(j) + CW'(1)) == count);
    sts.count_zero = (count == '0);
    sts.hash_eq    = (rd_hash == h);
    sts.byte_eq    = (rd_a == rd_canon);
    sts.out_busy   = out_valid && !out_ready;
  end

  // memories: registered reads every cycle at the current pointers
  always_ff @(posedge clk) begin
    rd_a     <= line_mem[pa];
    rd_b     <= line_mem[pb];
    rd_canon <= canon_mem[{j, i}];
    rd_hash  <= hash_mem[j];
    if (cmd.take && in_valid && pos < NW'(MAX_LEN)) begin
      line_mem[pos[LW-1:0]] <= char_byte;
    end
    if (cmd.hash_eval && !full) begin
      canon_mem[{count[EW-1:0], i}] <= rd_a;
    end
    if (cmd.commit && !full) begin
      hash_mem[count[EW-1:0]] <= h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      string_length <= STR_LEN_RESET;
      pos           <= '0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        string_length <= cfg_data;
      end
      if (cmd.take && in_valid) begin
        pos <= sts.str_done ? '0 : pos_inc;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (!full) begin
          count <= count + CW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_valid && sts.str_done) begin
      k    <= LW'(1);
      pa   <= LW'(1);
      pb   <= '0;
      i    <= '0;
      best <= '0;
    end
    if (cmd.rot_eval) begin
      if (rot_diff || sts.i_last) begin
        best <= best_new;
        k    <= k_inc;
        pa   <= k_inc;
        pb   <= best_new;
        i    <= '0;
      end else begin
        pa <= pa_adv;
        pb <= (NW'(pb) == n - NW'(1)) ? '0 : pb + LW'(1);
        i  <= i + LW'(1);
      end
    end
    if (cmd.hash_init) begin
      pa <= best;
      i  <= '0;
      h  <= '0;
    end
    if (cmd.hash_eval) begin
      h  <= h_mul + HASH_W'(rd_a);
      pa <= pa_adv;
      i  <= i + LW'(1);
      if (sts.i_last) begin
        j     <= '0;
        found <= 1'b0;
        match <= '0;
      end
    end
    if (cmd.scan_eval) begin
      if (sts.hash_eq) begin
        pa <= best;
        i  <= '0;
      end else begin
        j <= j + EW'(1);
      end
    end
    if (cmd.byte_eval) begin
      if (!sts.byte_eq) begin
        j <= j + EW'(1);
      end else begin
        pa <= pa_adv;
        i  <= i + LW'(1);
        if (sts.i_last) begin
          found <= 1'b1;
          match <= j;
        end
      end
    end
    if (cmd.commit) begin
      out_dup  <= found;
      out_full <= full;
      if (found || full) begin
        out_match <= INDEX_W'(match);
      end else begin
        out_match <= INDEX_W'(count);
      end
    end
  end

  assign match_index   = out_match;
  assign was_duplicate = out_dup;
  assign table_full    = out_full;
endmodule

// ===== test/cyclic_string_dedup_matcher_top_test.sv =====
`timescale 1ns / 1ps
module cyclic_string_dedup_matcher_top_test;
  import csdm_pkg::*;

  localparam int MAX_LEN     = MAX_LEN_DEF;
  localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
  // Worst gap between handshakes: a 64-byte rotation search plus a scan
  // where every stored entry hits on hash.
  localparam int STALL_LIMIT = 300000;
  localparam int LONG_HOLD   = 3000;

  typedef struct packed {
    logic [INDEX_W-1:0] match_index;
    logic               was_duplicate;
    logic               table_full;
  } match_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  csdm_char_if   char_in ();
  csdm_result_if result_out ();

  cyclic_string_dedup_matcher_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .char_in    (char_in),
    .result_out (result_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the matcher state.
  logic [CHAR_W-1:0] line_bytes [MAX_LEN];
  int unsigned       char_count = 0;
  logic [CFG_W-1:0]  length_reg = STR_LEN_RESET;
  logic [CHAR_W-1:0] dict_bytes [MAX_ENTRIES][MAX_LEN];
  logic [HASH_W-1:0] dict_hash [MAX_ENTRIES];
  int unsigned       dict_count = 0;

  match_t                 expected_matches [$];
  logic [8*MAX_LEN-1:0]   sent_strings [$];
  int                     errors = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     hold_request = 0;
  int                     hold_left = 0;
  int                     quiet_cycles = 0;
  bit                     handshake;
  match_t                 got, want;

  function automatic int eff_length();
    int n;
    n = length_reg;
    if (n == 0) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  function automatic bit rotation_less(int a, int b, int n);
    int k;
    for (k = 0; k < n; k++) begin
      if (line_bytes[(a + k) % n] != line_bytes[(b + k) % n])
        return line_bytes[(a + k) % n] < line_bytes[(b + k) % n];
    end
    return 1'b0;
  endfunction

  task automatic absorb_char(logic [CHAR_W-1:0] c);
    int                n, start, k, j, hit;
    logic [CHAR_W-1:0] canon [MAX_LEN];
    logic [HASH_W-1:0] h;
    bit                found, full;
    match_t            m;
    n = eff_length();
    if (char_count < MAX_LEN) line_bytes[char_count] = c;
    char_count++;
    if (char_count < n) return;
    char_count = 0;
    start = 0;
    for (k = 1; k < n; k++)
      if (rotation_less(k, start, n)) start = k;
    h = '0;
    for (k = 0; k < n; k++) begin
      canon[k] = line_bytes[(start + k) % n];
      h = h * HASH_SEED + HASH_W'(canon[k]);
    end
    found = 1'b0;
    hit = 0;
    for (j = 0; j < dict_count && !found; j++) begin
      if (dict_hash[j] == h) begin
        found = 1'b1;
        for (k = 0; k < n; k++)
          if (dict_bytes[j][k] != canon[k]) found = 1'b0;
        if (found) hit = j;
      end
    end
    full = dict_count >= MAX_ENTRIES;
    if (!full) begin
      for (k = 0; k < n; k++) dict_bytes[dict_count][k] = canon[k];
      dict_hash[dict_count] = h;
      if (!found) hit = dict_count;
      dict_count++;
    end
    m.match_index   = INDEX_W'(hit);
    m.was_duplicate = found;
    m.table_full    = full;
    expected_matches.push_back(m);
  endtask

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Result side: random ready with an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check each result against the oldest expectation; watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      handshake = char_in.valid && char_in.ready;
      if (result_out.valid && result_out.ready) begin
        handshake = 1'b1;
        got.match_index   = result_out.match_index;
        got.was_duplicate = result_out.was_duplicate;
        got.table_full    = result_out.table_full;
        if (expected_matches.size() == 0) begin
          report_error($sformatf("unexpected result index %0d", got.match_index));
        end else begin
          want = expected_matches.pop_front();
          if (got.match_index !== want.match_index)
            report_error($sformatf("match_index %0d, expected %0d",
                                   got.match_index, want.match_index));
          if (got.was_duplicate !== want.was_duplicate)
            report_error($sformatf("was_duplicate %0b, expected %0b",
                                   got.was_duplicate, want.was_duplicate));
          if (got.table_full !== want.table_full)
            report_error($sformatf("table_full %0b, expected %0b",
                                   got.table_full, want.table_full));
        end
      end
      quiet_cycles = handshake ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      char_in.valid <= 1'b0;
    end
    @(negedge clk);
    char_in.valid     <= 1'b1;
    char_in.char_byte <= c;
    do @(posedge clk); while (!char_in.ready);
    absorb_char(c);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    char_in.valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
  endtask

  task automatic write_length(logic [CFG_W-1:0] value);
    wait_drain();
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    length_reg = value;
    sent_strings.delete();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Mix rotations of earlier strings, two-symbol strings and random bytes.
  function automatic logic [8*MAX_LEN-1:0] make_string(int n);
    logic [8*MAX_LEN-1:0] s, p;
    logic [CHAR_W-1:0]    lo, hi;
    int                   mode, r, k;
    s = '0;
    mode = $urandom_range(9);
    if (mode < 4 && sent_strings.size() != 0) begin
      p = sent_strings[$urandom_range(sent_strings.size() - 1)];
      r = $urandom_range(n - 1);
      for (k = 0; k < n; k++) s[8*k +: 8] = p[8*((k + r) % n) +: 8];
    end else if (mode < 6) begin
      lo = ($urandom_range(1) != 0) ? 8'h00 : CHAR_W'($urandom);
      hi = ($urandom_range(1) != 0) ? 8'hFF : lo + 8'd1;
      for (k = 0; k < n; k++) s[8*k +: 8] = ($urandom_range(1) != 0) ? hi : lo;
    end else begin
      for (k = 0; k < n; k++) s[8*k +: 8] = CHAR_W'($urandom);
    end
    return s;
  endfunction

  task automatic send_string(logic [8*MAX_LEN-1:0] s);
    int k;
    for (k = 0; k < eff_length(); k++) send_char(s[8*k +: 8]);
    sent_strings.push_back(s);
  endtask

  task automatic send_random_strings(int count);
    int i;
    for (i = 0; i < count; i++) send_string(make_string(eff_length()));
  endtask

  // Lengths only shrink within this test so no row is read past its written bytes.
  task automatic test_longest_strings();
    logic [8*MAX_LEN-1:0] s, t;
    int                   k;
    set_idle(35, 68);
    write_length(7'd127);
    for (k = 0; k < MAX_LEN; k++) s[8*k +: 8] = (k % 9 == 0) ? 8'h00 : CHAR_W'($urandom);
    send_string(s);
    for (k = 0; k < MAX_LEN; k++) t[8*k +: 8] = s[8*((k + 17) % MAX_LEN) +: 8];
    send_string(t);
    write_length(7'd64);
    send_string({MAX_LEN{8'hFF}});
    send_string({MAX_LEN{8'h00}});
  endtask

  task automatic test_length_change_mid_string();
    int k;
    write_length(7'd20);
    for (k = 0; k < 10; k++) send_char(CHAR_W'($urandom));
    // Ten bytes already held: the next byte closes a six-byte string.
    write_length(7'd6);
    send_char(8'hA5);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(8'hFF);
  endtask

  task automatic test_random_lengths();
    write_length(7'd12);
    send_random_strings(4);
    write_length(7'd7);
    send_random_strings(6);
  endtask

  task automatic test_result_backpressure();
    set_idle(68, 35);
    write_length(7'd3);
    send_random_strings(5);
    hold_request = LONG_HOLD;
    send_random_strings(25);
  endtask

  task automatic test_drain_pause();
    set_idle(0, 0);
    write_length(7'd2);
    send_random_strings(10);
    wait_drain();
    send_random_strings(10);
  endtask

  // Length 0 acts as 1; fill the dictionary and keep going past full.
  task automatic test_table_full();
    int extra;
    write_length(7'd0);
    extra = 0;
    while (extra < 20) begin
      if (dict_count >= MAX_ENTRIES) extra++;
      send_string(make_string(1));
    end
  endtask

  initial begin
    char_in.valid      = 1'b0;
    char_in.char_byte  = '0;
    result_out.ready   = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_longest_strings();
    test_random_lengths();
    test_length_change_mid_string();
    test_result_backpressure();
    test_drain_pause();
    test_table_full();
    wait_drain();
    repeat (50) @(negedge clk);
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
